[src/mme_pkg.sv]
package mme_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int DIM_W = 4;

  localparam logic [1:0] REQ_WR_A = 2'd0;
  localparam logic [1:0] REQ_WR_B = 2'd1;
  localparam logic [1:0] REQ_RUN  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_B_COLS    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_WR_A,
    OP_WR_B,
    OP_RUN
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         elem_row;
    logic [2:0]         elem_col;
    logic signed [31:0] elem_value;
  } req_word_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               last_result;
  } res_word_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] inner_dim;
    logic [DIM_W-1:0] b_cols;
  } dims_t;

endpackage

[src/mme_front.sv]
module mme_front #(
  parameter int MAX_DIM = 8
) (
  input  logic               req_valid,
  output logic               req_stall,
  input  mme_pkg::req_word_t req,
  input  mme_pkg::q_stat_t   q_stat,
  output logic               q_push,
  output mme_pkg::cmd_t      q_cmd
);

  logic [2:0] row;
  logic [2:0] col;

  assign req_stall = q_stat.full;

  always_comb begin
    row = req.elem_row;
    col = req.elem_col;
    for (int s = 0; s < 7; s++) begin
      if (int'(row) >= MAX_DIM) begin
        row = row - 3'(MAX_DIM);
      end
      if (int'(col) >= MAX_DIM) begin
        col = col - 3'(MAX_DIM);
      end
    end
  end

  always_comb begin
    q_push      = 1'b0;
    q_cmd.op    = mme_pkg::OP_RUN;
    q_cmd.row   = row;
    q_cmd.col   = col;
    q_cmd.value = req.elem_value;
    unique case (req.req_type)
      mme_pkg::REQ_WR_A: begin
        q_push   = req_valid && !q_stat.full;
        q_cmd.op = mme_pkg::OP_WR_A;
      end
      mme_pkg::REQ_WR_B: begin
        q_push   = req_valid && !q_stat.full;
        q_cmd.op = mme_pkg::OP_WR_B;
      end
      mme_pkg::REQ_RUN: begin
        q_push   = req_valid && !q_stat.full;
        q_cmd.op = mme_pkg::OP_RUN;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

[src/mme_queue.sv]
module mme_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mme_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output mme_pkg::cmd_t    head,
  output mme_pkg::q_stat_t stat
);

  localparam int DEPTH = mme_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  mme_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[src/mme_back.sv]
module mme_back #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  mme_pkg::dims_t     dims,
  input  mme_pkg::q_stat_t   q_stat,
  input  mme_pkg::cmd_t      head,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_stall,
  output mme_pkg::res_word_t res
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ACC_W = 65 + $clog2(MAX_DIM);

  function automatic logic [IW-1:0] last_index(input logic [mme_pkg::DIM_W-1:0] v);
    logic [IW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_DIM) begin
      r = IW'(MAX_DIM - 1);
    end else begin
      r = IW'(v - 4'd1);
    end
    return r;
  endfunction

  mme_pkg::bk_state_t state;
  mme_pkg::bk_state_t state_next;

  logic [IW-1:0] i, i_next;
  logic [IW-1:0] j, j_next;
  logic [IW-1:0] k, k_next;
  logic [IW-1:0] m_last, n_last, p_last;

  logic adv, issue, start, wr_a, wr_b;
  logic at_i_end, at_j_end, at_k_end;

  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [31:0]   mem_a [DEPTH];
  logic [31:0]   mem_b [DEPTH];

  logic signed [31:0] rd_a, rd_b;
  logic               s1_valid, s1_first, s1_lastk, s1_lastres;
  logic [IW-1:0]      s1_i, s1_j;

  logic signed [63:0] prod;
  logic               s2_valid, s2_first, s2_lastk, s2_lastres;
  logic [IW-1:0]      s2_i, s2_j;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod_ext;
  logic                    s3_valid, s3_lastres;
  logic [IW-1:0]           s3_i, s3_j;

  logic signed [ACC_W-1:0] shifted;
  logic [ACC_W-32:0]       upper;
  logic signed [31:0]      sat;

  assign adv      = !res_valid || !res_stall;
  assign issue    = (state == mme_pkg::BK_RUN) && adv;
  assign at_i_end = (i == m_last);
  assign at_j_end = (j == p_last);
  assign at_k_end = (k == n_last);
  assign start    = pop && (head.op == mme_pkg::OP_RUN);

  assign wr_addr   = AW'(head.row * MAX_DIM + head.col);
  assign rd_addr_a = AW'(i * MAX_DIM + k);
  assign rd_addr_b = AW'(k * MAX_DIM + j);

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    pop        = 1'b0;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    unique case (state)
      mme_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          unique case (head.op)
            mme_pkg::OP_WR_A: wr_a = 1'b1;
            mme_pkg::OP_WR_B: wr_b = 1'b1;
            mme_pkg::OP_RUN: begin
              state_next = mme_pkg::BK_RUN;
              i_next     = '0;
              j_next     = '0;
              k_next     = '0;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      mme_pkg::BK_RUN: begin
        if (adv) begin
          k_next = at_k_end ? '0 : k + IW'(1);
          if (at_k_end) begin
            j_next = at_j_end ? '0 : j + IW'(1);
            if (at_j_end) begin
              i_next = i + IW'(1);
              if (at_i_end) begin
                i_next     = '0;
                state_next = mme_pkg::BK_IDLE;
              end
            end
          end
        end
      end
      default: begin
        state_next = mme_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mme_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    i <= i_next;
    j <= j_next;
    k <= k_next;
    if (start) begin
      m_last <= last_index(dims.a_rows);
      n_last <= last_index(dims.inner_dim);
      p_last <= last_index(dims.b_cols);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= head.value;
    end
    if (issue) begin
      rd_a <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[wr_addr] <= head.value;
    end
    if (issue) begin
      rd_b <= mem_b[rd_addr_b];
    end
  end

  assign prod_ext = {{(ACC_W - 64){prod[63]}}, prod};

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first   <= (k == '0);
      s1_lastk   <= at_k_end;
      s1_lastres <= at_i_end && at_j_end;
      s1_i       <= i;
      s1_j       <= j;

      prod       <= rd_a * rd_b;
      s2_first   <= s1_first;
      s2_lastk   <= s1_lastk;
      s2_lastres <= s1_lastres;
      s2_i       <= s1_i;
      s2_j       <= s1_j;

      if (s2_valid) begin
        acc <= s2_first ? prod_ext : acc + prod_ext;
      end
      s3_lastres <= s2_lastres;
      s3_i       <= s2_i;
      s3_j       <= s2_j;

      res.out_row     <= 3'(s3_i);
      res.out_col     <= 3'(s3_j);
      res.out_value   <= sat;
      res.last_result <= s3_lastres;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= (state == mme_pkg::BK_RUN);
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid && s2_lastk;
      res_valid <= s3_valid;
    end
  end

  always_comb begin
    shifted = acc >>> FRAC_BITS;
    upper   = shifted[ACC_W-1:31];
    if ((&upper) || !(|upper)) begin
      sat = shifted[31:0];
    end else if (shifted[ACC_W-1]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7FFF_FFFF;
    end
  end

endmodule

[src/matrix_multiply_engine_core.sv]
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | req_word_t: req_type, elem_row, elem_col, value
// res     | out       | res_valid/res_stall  | res_word_t: out_row, out_col, out_value, last
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data (a_rows, inner_dim, b_cols)
//
// Element writes pass the command queue and retire one per cycle in the idle back end.
// A run issues one multiply-accumulate per cycle unless the result is stalled, through the
// single read port of each store, then read, product, accumulator and result registers.
// Reset (rst, synchronous) empties the queue and pipeline and sets all sizes to 8;
// the stores hold nothing defined until written.
// A stalled result freezes the whole run pipeline; requests stall only when the queue fills.
module matrix_multiply_engine_core #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  mme_pkg::req_word_t                  req,
  output logic                                res_valid,
  input  logic                                res_stall,
  output mme_pkg::res_word_t                  res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mme_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]           cfg_data
);

  mme_pkg::dims_t   dims;
  mme_pkg::q_stat_t q_stat;
  mme_pkg::cmd_t    q_cmd;
  mme_pkg::cmd_t    head;
  logic             q_push;
  logic             pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.a_rows    <= mme_pkg::DIM_RESET;
      dims.inner_dim <= mme_pkg::DIM_RESET;
      dims.b_cols    <= mme_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mme_pkg::CFG_A_ROWS:    dims.a_rows    <= cfg_data;
        mme_pkg::CFG_INNER_DIM: dims.inner_dim <= cfg_data;
        mme_pkg::CFG_B_COLS:    dims.b_cols    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mme_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  mme_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  mme_back #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .dims     (dims),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    q_push |=> !q_stat.empty)
    else $error("pushed command missing from queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");
`endif

endmodule
